/* rtl/hpsr_pkg.sv */
// ----------------------------------------------------------------------------
// hpsr_pkg
// Shared types and constants for the handle pool with swap-remove.
// ----------------------------------------------------------------------------
package hpsr_pkg;

  // Field widths of the command and result words
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned HANDLE_W = 10;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned STATUS_W = 2;

  // Default pool capacity and reset value of the live limit
  localparam int unsigned      POOL_SIZE_DEFAULT = 1024;
  localparam logic [COUNT_W-1:0] LIMIT_RESET     = 11'd1024;

  typedef enum logic [KIND_W-1:0] {
    KIND_CREATE = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_READ   = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_DEAD = 2'd2
  } status_e;

  // Controller to datapath
  typedef struct packed {
    logic clear;   // write one identity entry of both maps
    logic accept;  // capture a command word
    logic eval;    // read data back, decide the outcome
    logic swap;    // second write pass of a live remove
  } hpsr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;  // final entry of the clearing pass
    logic swap_req;    // remove hit a live handle
  } hpsr_stat_t;

endpackage

/* rtl/hpsr_ram.sv */
// ----------------------------------------------------------------------------
// hpsr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module hpsr_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/hpsr_ctrl.sv */
// ----------------------------------------------------------------------------
// hpsr_ctrl
// Sequencer: clearing pass after reset, then accept / evaluate / swap.
// ----------------------------------------------------------------------------
module hpsr_ctrl import hpsr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  hpsr_stat_t stat_i,
  output hpsr_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_EVAL  = 4'b0100,
    ST_SWAP  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = stat_i.swap_req ? ST_SWAP : ST_IDLE;
      end
      ST_SWAP: begin
        cmd_o.swap = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

/* rtl/hpsr_dpath.sv */
// ----------------------------------------------------------------------------
// hpsr_dpath
// Datapath: dense map, inverse map, live count, limit register and result.
// ----------------------------------------------------------------------------
module hpsr_dpath import hpsr_pkg::*; #(
  parameter int unsigned POOL_SIZE = POOL_SIZE_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hpsr_cmd_t           cmd_i,
  output hpsr_stat_t          stat_o,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [HANDLE_W-1:0] handle_i,
  input  logic [HANDLE_W-1:0] position_i,
  input  logic                live_limit_we_i,
  input  logic [COUNT_W-1:0]  live_limit_i,
  output logic                result_valid_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [HANDLE_W-1:0] handle_out_o,
  output logic [COUNT_W-1:0]  live_count_o
);

  localparam int unsigned AW = $clog2(POOL_SIZE);
  localparam int unsigned CW = $clog2(POOL_SIZE + 1);

  // Registers
  logic [CW-1:0]       count_q, count_d;
  logic [COUNT_W-1:0]  limit_q;
  logic [AW-1:0]       clr_q;
  kind_e               kind_q;
  logic [AW-1:0]       handle_q;
  logic                in_range_q;
  logic [AW-1:0]       pos_q, pos_d;
  logic [AW-1:0]       moved_q, moved_d;
  logic                valid_q, valid_d;
  status_e             status_q, status_d;
  logic [HANDLE_W-1:0] hout_q, hout_d;

  // RAM ports
  logic          hap_we, poh_we;
  logic [AW-1:0] hap_waddr, hap_wdata, poh_waddr, poh_wdata;
  logic [AW-1:0] hap_raddr, poh_raddr;
  logic [AW-1:0] hap_rd, poh_rd;

  logic [AW-1:0] last;
  logic [CW-1:0] limit_eff;
  logic          full;
  logic          in_range;

  hpsr_ram #(.WIDTH(AW), .DEPTH(POOL_SIZE)) u_hap_ram (
    .clk_i   (clk_i),
    .we_i    (hap_we),
    .waddr_i (hap_waddr),
    .wdata_i (hap_wdata),
    .raddr_i (hap_raddr),
    .rdata_o (hap_rd)
  );

  hpsr_ram #(.WIDTH(AW), .DEPTH(POOL_SIZE)) u_poh_ram (
    .clk_i   (clk_i),
    .we_i    (poh_we),
    .waddr_i (poh_waddr),
    .wdata_i (poh_wdata),
    .raddr_i (poh_raddr),
    .rdata_o (poh_rd)
  );

  // Last live position and the limit in force
  assign last      = AW'(count_q - CW'(1));
  assign limit_eff = (32'(limit_q) < 32'(POOL_SIZE)) ? CW'(limit_q) : CW'(POOL_SIZE);
  assign full      = (count_q >= limit_eff);

  // Range check of the incoming handle or position
  always_comb begin
    if (kind_e'(kind_i) == KIND_READ) begin
      in_range = (32'(position_i) < 32'(POOL_SIZE));
    end else begin
      in_range = (32'(handle_i) < 32'(POOL_SIZE));
    end
  end

  // Read addresses, taken from the word on the accept edge
  always_comb begin
    unique case (kind_e'(kind_i))
      KIND_READ:   hap_raddr = AW'(position_i);
      KIND_CREATE: hap_raddr = AW'(count_q);
      default:     hap_raddr = last;
    endcase
  end
  assign poh_raddr = AW'(handle_i);

  // Status towards the controller
  assign stat_o.clear_last = (clr_q == AW'(POOL_SIZE - 1));
  assign stat_o.swap_req   = (kind_q == KIND_REMOVE) && in_range_q
                             && (CW'(poh_rd) < count_q);

  // Map writes: identity fill, then the two halves of a swap
  always_comb begin
    hap_we    = 1'b0;
    hap_waddr = clr_q;
    hap_wdata = clr_q;
    poh_we    = 1'b0;
    poh_waddr = clr_q;
    poh_wdata = clr_q;
    if (cmd_i.clear) begin
      hap_we = 1'b1;
      poh_we = 1'b1;
    end else if (cmd_i.eval && stat_o.swap_req) begin
      hap_we    = 1'b1;
      hap_waddr = poh_rd;
      hap_wdata = hap_rd;
      poh_we    = 1'b1;
      poh_waddr = handle_q;
      poh_wdata = last;
    end else if (cmd_i.swap) begin
      hap_we    = 1'b1;
      hap_waddr = last;
      hap_wdata = handle_q;
      poh_we    = 1'b1;
      poh_waddr = moved_q;
      poh_wdata = pos_q;
    end
  end

  // Outcome of a word and the count update
  always_comb begin
    count_d  = count_q;
    pos_d    = pos_q;
    moved_d  = moved_q;
    valid_d  = 1'b0;
    status_d = status_q;
    hout_d   = hout_q;
    if (cmd_i.eval) begin
      status_d = STATUS_OK;
      hout_d   = '0;
      unique case (kind_q)
        KIND_CREATE: begin
          valid_d = 1'b1;
          if (full) begin
            status_d = STATUS_FULL;
          end else begin
            hout_d  = HANDLE_W'(hap_rd);
            count_d = count_q + CW'(1);
          end
        end
        KIND_REMOVE: begin
          if (stat_o.swap_req) begin
            pos_d   = poh_rd;
            moved_d = hap_rd;
          end else begin
            valid_d  = 1'b1;
            status_d = STATUS_DEAD;
          end
        end
        KIND_READ: begin
          valid_d = 1'b1;
          if (in_range_q) begin
            hout_d = HANDLE_W'(hap_rd);
          end
        end
        default: begin
          valid_d = 1'b1;
        end
      endcase
    end else if (cmd_i.swap) begin
      valid_d  = 1'b1;
      status_d = STATUS_OK;
      hout_d   = '0;
      count_d  = CW'(last);
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      limit_q <= LIMIT_RESET;
      clr_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      valid_q <= valid_d;
      if (live_limit_we_i) begin
        limit_q <= live_limit_i;
      end
      if (cmd_i.clear) begin
        clr_q <= clr_q + AW'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q     <= kind_e'(kind_i);
      handle_q   <= AW'(handle_i);
      in_range_q <= in_range;
    end
    pos_q    <= pos_d;
    moved_q  <= moved_d;
    status_q <= status_d;
    hout_q   <= hout_d;
  end

  assign result_valid_o = valid_q;
  assign status_o       = status_q;
  assign handle_out_o   = hout_q;
  assign live_count_o   = COUNT_W'(count_q);

endmodule

/* rtl/handle_pool_swap_remove.sv */
// ----------------------------------------------------------------------------
// handle_pool_swap_remove
// Fixed pool of handles kept as a sparse set with swap-remove.
// ----------------------------------------------------------------------------
//  channel   | handshake               | word
//  ----------+-------------------------+---------------------------------------
//  command   | start / busy            | kind_i, handle_i, position_i
//  result    | result_valid_o (strobe) | status_o, handle_out_o, live_count_o
//  config    | live_limit_we_i         | live_limit_i
//
//  Create, read and a dead remove pass the accept and evaluate states; a live
//  remove adds the swap state, as it makes two write passes over the map RAMs.
//  The result strobe shows in the cycle a new word may already be accepted.
//  After reset a clearing pass writes the identity into every entry of both
//  maps; busy stays high meanwhile. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module handle_pool_swap_remove import hpsr_pkg::*; #(
  parameter int unsigned POOL_SIZE = POOL_SIZE_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [HANDLE_W-1:0] handle_i,
  input  logic [HANDLE_W-1:0] position_i,
  input  logic                live_limit_we_i,
  input  logic [COUNT_W-1:0]  live_limit_i,
  output logic                result_valid_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [HANDLE_W-1:0] handle_out_o,
  output logic [COUNT_W-1:0]  live_count_o
);

  hpsr_cmd_t  cmd;
  hpsr_stat_t stat;

  hpsr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  hpsr_dpath #(.POOL_SIZE(POOL_SIZE)) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .kind_i          (kind_i),
    .handle_i        (handle_i),
    .position_i      (position_i),
    .live_limit_we_i (live_limit_we_i),
    .live_limit_i    (live_limit_i),
    .result_valid_o  (result_valid_o),
    .status_o        (status_o),
    .handle_out_o    (handle_out_o),
    .live_count_o    (live_count_o)
  );

endmodule

/* rtl/hpsr_checker.sv */
// ----------------------------------------------------------------------------
// hpsr_checker
// Port-level checks on the handle pool, bound to the top level.
// ----------------------------------------------------------------------------
module hpsr_checker import hpsr_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                result_valid_o,
  input logic [STATUS_W-1:0] status_o,
  input logic [HANDLE_W-1:0] handle_out_o,
  input logic [COUNT_W-1:0]  live_count_o
);

  // An accepted word keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a word");

  // One word never yields results in two consecutive cycles
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for two cycles");

  // The live count only moves together with a result
  a_count_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(live_count_o) |-> result_valid_o)
    else $error("live count changed without a result");

  // A refused create hands out no handle
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o == STATUS_FULL)) |-> (handle_out_o == '0))
    else $error("refused create returned a handle");

  // A remove of a dead handle leaves the count alone
  a_dead_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o == STATUS_DEAD)) |-> $stable(live_count_o))
    else $error("dead remove changed the live count");

endmodule

bind handle_pool_swap_remove hpsr_checker u_hpsr_checker (.*);

/* tb/tb_handle_pool_swap_remove.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_handle_pool_swap_remove
// Self-checking bench for the swap-remove handle pool. A local copy of both
// maps, the live count and the limit predicts every result word; a checker
// process compares each strobed word against the oldest prediction. Directed
// tests cover the pool edges, random phases sweep the live limit, and a final
// test fills the pool up to a lowered limit.
// ----------------------------------------------------------------------------
module tb_handle_pool_swap_remove;
  import hpsr_pkg::*;

  localparam int unsigned          POOL        = POOL_SIZE_DEFAULT;
  localparam logic [COUNT_W-1:0]   POOL_CAP    = COUNT_W'(POOL);
  localparam logic [COUNT_W-1:0]   FILL_LIMIT  = 11'd64;
  localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;

  typedef struct packed {
    status_e             status;
    logic [HANDLE_W-1:0] handle;
    logic [COUNT_W-1:0]  count;
  } pool_word_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [KIND_W-1:0]   kind_i;
  logic [HANDLE_W-1:0] handle_i;
  logic [HANDLE_W-1:0] position_i;
  logic                live_limit_we_i;
  logic [COUNT_W-1:0]  live_limit_i;
  logic                result_valid_o;
  logic [STATUS_W-1:0] status_o;
  logic [HANDLE_W-1:0] handle_out_o;
  logic [COUNT_W-1:0]  live_count_o;

  // Local copy of the pool state
  logic [HANDLE_W-1:0] pool_handle_at [POOL];
  logic [HANDLE_W-1:0] pool_pos_of    [POOL];
  logic [COUNT_W-1:0]  pool_live;
  logic [COUNT_W-1:0]  pool_limit;

  pool_word_t  pending_words[$];
  bit          no_gaps;
  int unsigned n_errors, n_words, n_results;
  int unsigned n_full, n_dead, n_swaps, peak_live;

  handle_pool_swap_remove dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .kind_i          (kind_i),
    .handle_i        (handle_i),
    .position_i      (position_i),
    .live_limit_we_i (live_limit_we_i),
    .live_limit_i    (live_limit_i),
    .result_valid_o  (result_valid_o),
    .status_o        (status_o),
    .handle_out_o    (handle_out_o),
    .live_count_o    (live_count_o)
  );

  always #6 clk_i = ~clk_i;

  // Predict one command and advance the local pool state
  function automatic pool_word_t apply_pool_op(input logic [KIND_W-1:0] k,
                                               input logic [HANDLE_W-1:0] h,
                                               input logic [HANDLE_W-1:0] p);
    pool_word_t          w;
    logic [COUNT_W-1:0]  cap;
    logic [COUNT_W-1:0]  last;
    logic [HANDLE_W-1:0] slot;
    logic [HANDLE_W-1:0] moved;
    w.status = STATUS_OK;
    w.handle = '0;
    cap = (pool_limit < POOL_CAP) ? pool_limit : POOL_CAP;
    case (k)
      KIND_CREATE: begin
        if (pool_live >= cap) begin
          w.status = STATUS_FULL;
          n_full++;
        end else begin
          w.handle = pool_handle_at[pool_live];
          pool_live++;
        end
      end
      KIND_REMOVE: begin
        slot = pool_pos_of[h];
        if (slot >= pool_live) begin
          w.status = STATUS_DEAD;
          n_dead++;
        end else begin
          // swap with the last live entry; a self-swap only shrinks the count
          last  = pool_live - 1'b1;
          moved = pool_handle_at[last];
          pool_handle_at[slot] = moved;
          pool_handle_at[last] = h;
          pool_pos_of[h]       = last[HANDLE_W-1:0];
          pool_pos_of[moved]   = slot;
          pool_live            = last;
          n_swaps++;
        end
      end
      KIND_READ: w.handle = pool_handle_at[p];
      default: ;
    endcase
    if (pool_live > peak_live) peak_live = pool_live;
    w.count = pool_live;
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at word %0d: %s", n_results, msg);
    n_errors++;
  endtask

  // Idle gap before a command: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Send one command word; start stays high after acceptance
  task automatic send_word(input logic [KIND_W-1:0] k, input logic [HANDLE_W-1:0] h,
                           input logic [HANDLE_W-1:0] p);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start      <= 1'b1;
    kind_i     <= k;
    handle_i   <= h;
    position_i <= p;
    do @(posedge clk_i); while (busy !== 1'b0);
    pending_words.push_back(apply_pool_op(k, h, p));
    n_words++;
  endtask

  // Drop start and let every outstanding result come back
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_live_limit(input logic [COUNT_W-1:0] v);
    wait_idle();
    live_limit_we_i <= 1'b1;
    live_limit_i    <= v;
    @(posedge clk_i);
    live_limit_we_i <= 1'b0;
    pool_limit = v;
  endtask

  task automatic random_command();
    int unsigned         r;
    logic [KIND_W-1:0]   k;
    logic [HANDLE_W-1:0] h;
    logic [HANDLE_W-1:0] p;
    r = $urandom_range(99);
    h = HANDLE_W'($urandom);
    p = HANDLE_W'($urandom);
    if (r < 45) begin
      k = KIND_CREATE;
    end else if (r < 75) begin
      // remove a handle that is live now
      k = KIND_REMOVE;
      if (pool_live != 0) h = pool_handle_at[$urandom_range(pool_live - 1)];
    end else if (r < 83) begin
      k = KIND_REMOVE;
    end else if (r < 95) begin
      k = KIND_READ;
      if (pool_live != 0 && r < 90) p = HANDLE_W'($urandom_range(pool_live - 1));
    end else begin
      k = KIND_UNUSED;
    end
    send_word(k, h, p);
  endtask

  // Empty pool straight after the clearing pass
  task automatic test_after_reset();
    send_word(KIND_READ, '0, '0);
    send_word(KIND_READ, '1, '1);
    send_word(KIND_READ, 10'h155, 10'h2AA);
    send_word(KIND_REMOVE, '0, '0);
    send_word(KIND_REMOVE, '1, '1);
    send_word(KIND_UNUSED, '1, '1);
    send_word(KIND_CREATE, 10'h2AA, 10'h155);
  endtask

  // Limit of zero and one, self-swap, middle swap, limit below the count
  task automatic test_limit_edges();
    int unsigned i;
    set_live_limit('0);
    send_word(KIND_CREATE, '0, '0);
    send_word(KIND_REMOVE, '0, '0);
    set_live_limit(11'd1);
    send_word(KIND_CREATE, '0, '0);
    send_word(KIND_CREATE, '1, '1);
    send_word(KIND_REMOVE, '0, '0);
    send_word(KIND_REMOVE, '0, '0);
    set_live_limit('1);
    for (i = 0; i < 4; i++) send_word(KIND_CREATE, '0, '0);
    send_word(KIND_REMOVE, 10'd1, '0);
    for (i = 0; i < 4; i++) send_word(KIND_READ, '0, HANDLE_W'(i));
    send_word(KIND_REMOVE, '1, '0);
    send_word(KIND_REMOVE, 10'd1, '0);
    set_live_limit(11'd2);
    send_word(KIND_CREATE, '0, '0);
    send_word(KIND_UNUSED, '0, '0);
  endtask

  // Random traffic over a sweep of limits, some phases without gaps
  task automatic test_random_phases();
    logic [COUNT_W-1:0] limits [8];
    int unsigned        ph, i;
    limits = '{11'd200, 11'd31, 11'd5, 11'd1024, 11'd1, 11'd2047, 11'd2, 11'd0};
    limits[7] = COUNT_W'($urandom_range(1, 1024));
    for (ph = 0; ph < 8; ph++) begin
      set_live_limit(limits[ph]);
      no_gaps = (ph % 3 == 1);
      for (i = 0; i < 48; i++) random_command();
    end
    no_gaps = 0;
  endtask

  // Fill up to a lowered limit, refuse one more, then shrink a little
  task automatic test_pool_capacity();
    int unsigned i;
    set_live_limit(FILL_LIMIT);
    no_gaps = 1;
    while (pool_live < FILL_LIMIT)
      send_word(KIND_CREATE, HANDLE_W'($urandom), HANDLE_W'($urandom));
    send_word(KIND_CREATE, HANDLE_W'($urandom), HANDLE_W'($urandom));
    send_word(KIND_READ, HANDLE_W'($urandom), '1);
    for (i = 0; i < 20; i++) send_word(KIND_REMOVE, pool_handle_at[$urandom_range(POOL - 1)], '0);
    no_gaps = 0;
    set_live_limit(LIMIT_RESET);
    for (i = 0; i < 30; i++) random_command();
  endtask

  // Result checker: every strobed word against the oldest prediction
  always @(posedge clk_i) begin
    pool_word_t want;
    if (rst_ni && result_valid_o === 1'b1) begin
      n_results++;
      if (pending_words.size() == 0) begin
        report_mismatch("result word with no command outstanding");
      end else begin
        want = pending_words.pop_front();
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
        if (handle_out_o !== want.handle)
          report_mismatch($sformatf("handle %0d, expected %0d", handle_out_o, want.handle));
        if (live_count_o !== want.count)
          report_mismatch($sformatf("live count %0d, expected %0d", live_count_o, want.count));
      end
    end
  end

  // Main sequence
  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    start           = 1'b0;
    kind_i          = KIND_CREATE;
    handle_i        = '0;
    position_i      = '0;
    live_limit_we_i = 1'b0;
    live_limit_i    = LIMIT_RESET;
    no_gaps         = 0;
    n_errors = 0; n_words = 0; n_results = 0;
    n_full = 0; n_dead = 0; n_swaps = 0; peak_live = 0;
    for (int i = 0; i < POOL; i++) begin
      pool_handle_at[i] = HANDLE_W'(i);
      pool_pos_of[i]    = HANDLE_W'(i);
    end
    pool_live  = '0;
    pool_limit = LIMIT_RESET;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_after_reset();
    test_limit_edges();
    test_random_phases();
    test_pool_capacity();

    wait_idle();
    repeat (8) @(posedge clk_i);
    $display("Ran %0d command words, checked %0d result words, peak live count %0d.",
             n_words, n_results, peak_live);
    $display("Refused creates: %0d, removes of dead handles: %0d, swap-removes: %0d.",
             n_full, n_dead, n_swaps);
    if (n_errors == 0 && pending_words.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("Watchdog expired with %0d results outstanding.", pending_words.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
